// File: hw/rtl/ssnps_pkg.sv
`default_nettype none

package ssnps_pkg;

    // window depth: the longest keyphrase plus its leading boundary byte
    localparam int WIN_DEPTH      = 23;
    // bytes of the window that a token check looks at
    localparam int CLOSE_SPAN     = 12;
    localparam int DEF_COUNT_BITS = 16;

    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5A;
    localparam logic [7:0] CH_LOA   = 8'h61;
    localparam logic [7:0] CH_LOZ   = 8'h7A;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // keyphrases, first character in the top byte
    localparam int LEN_A = 22;
    localparam int LEN_B = 3;
    localparam int LEN_C = 10;
    localparam logic [8*LEN_A-1:0] PHRASE_A = "social security number";
    localparam logic [8*LEN_B-1:0] PHRASE_B = "ssn";
    localparam logic [8*LEN_C-1:0] PHRASE_C = "student id";

    // numbers that never score, as packed decimal digits
    localparam logic [35:0] AD_NUM_A    = 36'h078051120;
    localparam logic [35:0] AD_NUM_B    = 36'h457555462;
    localparam logic [31:0] AD_PREFIX   = 32'h98765432;

    // area bands
    localparam logic [9:0] AREA_BAD     = 10'd666;
    localparam logic [9:0] AREA_HI_END  = 10'd734;
    localparam logic [9:0] AREA_MID_END = 10'd750;
    localparam logic [9:0] AREA_HI2_END = 10'd773;
    localparam logic [9:0] AREA_LIMIT   = 10'd900;

    typedef struct packed {
        logic [7:0] chr;
        logic [7:0] low;
        logic       digit;
        logic       word;
    } t_char;

    // byte classification, carried along the window with the byte
    function automatic t_char classify(input logic [7:0] c);
        t_char r;
        logic  upper;
        logic  lower;
        upper   = (c >= CH_UPA) && (c <= CH_UPZ);
        lower   = (c >= CH_LOA) && (c <= CH_LOZ);
        r.chr   = c;
        r.low   = upper ? (c + 8'd32) : c;
        r.digit = (c >= CH_ZERO) && (c <= CH_NINE);
        r.word  = r.digit || upper || lower || (c == CH_UNDER);
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ssn_pattern_scanner.sv
// Identity-number scanner for a byte stream of text.
// Input channel (i_valid / o_ready): one text byte per request in i_char_byte;
// i_last_byte marks the final byte of a text. A zero byte ends the text early;
// later bytes up to the last one are taken and ignored.
// Output channel (o_valid / i_ready): one result per text, priority 0..3 in
// o_priority_res and the count of scoring hits in o_match_count.
// Throughput: one byte per cycle while o_ready is high. The window is a row of
// 23 byte cells that shift on each accepted byte up to the first zero byte,
// except the last byte, which clears them; token and keyphrase checks run on
// that row. Checks feed a check register, scoring the output register.
// A finished result waits in the output register while further bytes are
// taken; only a second last byte stalls o_ready until the result is taken.
// After the last byte the window and all totals are back at their reset
// values, so the next text may follow in the next cycle.
// Reset (i_rst_n low, synchronous) empties the window, totals and both
// pipeline registers; the output channel offers nothing.
`default_nettype none

module ssn_pattern_scanner #(
    parameter int COUNT_BITS = ssnps_pkg::DEF_COUNT_BITS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_char_byte,
    input  wire         i_last_byte,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_priority_res,
    output logic [15:0] o_match_count
);

    localparam int DEPTH = ssnps_pkg::WIN_DEPTH;
    localparam int SPAN  = ssnps_pkg::CLOSE_SPAN;

    ssnps_pkg::t_char cin;
    ssnps_pkg::t_char cell_q    [DEPTH];
    ssnps_pkg::t_char win_push  [DEPTH];
    ssnps_pkg::t_char view      [SPAN];

    logic        accept;
    logic        stall;
    logic        active;
    logic        shift_en;
    logic        clear_en;
    logic        close_en;
    logic        use_push;
    logic        dash_form;
    logic        tok_ok;
    logic [35:0] tok_digits;
    logic        ph_a;
    logic        ph_b;
    logic        ph_c;
    logic        phrase_hit;

    logic        r_stopped;
    logic        r_b_valid;
    logic        r_b_last;
    logic        r_b_hit;
    logic        r_b_phrase;
    logic [35:0] r_b_digits;

    logic [1:0]            r_best;
    logic [COUNT_BITS-1:0] r_total;
    logic                  r_phrase;
    logic [1:0]            n_best;
    logic [COUNT_BITS-1:0] n_total;
    logic                  n_phrase;
    logic [1:0]            hit_score;
    logic                  scored;
    logic [1:0]            n_pri;
    logic [COUNT_BITS+15:0] total_ext;

    logic       r_out_valid;
    logic [1:0] r_out_pri;
    logic [15:0] r_out_count;

    // handshake: hold off only when a result is stuck and another is due
    assign stall   = r_b_valid && r_b_last && r_out_valid && !i_ready;
    assign o_ready = !stall;
    assign accept  = i_valid && o_ready;

    assign cin      = ssnps_pkg::classify(i_char_byte);
    assign active   = accept && !r_stopped;
    assign shift_en = active && (i_char_byte != 8'h00) && !i_last_byte;
    assign clear_en = accept && i_last_byte;

    // window cells, newest byte in cell 0
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            ssnps_pkg::t_char cell_in;
            if (g == 0) begin : g_head
                assign cell_in = cin;
            end else begin : g_body
                assign cell_in = cell_q[g-1];
            end
            assign win_push[g] = cell_in;
            ssnps_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift_en),
                .i_clear (clear_en),
                .i_data  (cell_in),
                .o_data  (cell_q[g])
            );
        end
    endgenerate

    // token closes on a boundary byte, or at the end of text after a word byte
    assign close_en = active && ((i_char_byte == 8'h00) || !cin.word || i_last_byte);
    assign use_push = (i_char_byte != 8'h00) && cin.word;

    always_comb begin
        for (int j = 0; j < SPAN; j++) begin
            view[j] = use_push ? win_push[j] : cell_q[j];
        end
    end

    // token shape check: ddd-dd-dddd or nine digits, word start before it
    assign dash_form = (view[7].chr == ssnps_pkg::CH_DASH);
    always_comb begin
        if (dash_form) begin
            tok_ok = !view[11].word && (view[4].chr == ssnps_pkg::CH_DASH)
                   && view[10].digit && view[9].digit && view[8].digit
                   && view[6].digit && view[5].digit
                   && view[3].digit && view[2].digit && view[1].digit && view[0].digit;
            tok_digits = {view[10].chr[3:0], view[9].chr[3:0], view[8].chr[3:0],
                          view[6].chr[3:0], view[5].chr[3:0],
                          view[3].chr[3:0], view[2].chr[3:0], view[1].chr[3:0],
                          view[0].chr[3:0]};
        end else begin
            tok_ok = !view[9].word
                   && view[8].digit && view[7].digit && view[6].digit
                   && view[5].digit && view[4].digit && view[3].digit
                   && view[2].digit && view[1].digit && view[0].digit;
            tok_digits = {view[8].chr[3:0], view[7].chr[3:0], view[6].chr[3:0],
                          view[5].chr[3:0], view[4].chr[3:0], view[3].chr[3:0],
                          view[2].chr[3:0], view[1].chr[3:0], view[0].chr[3:0]};
        end
    end

    // keyphrases ending at the newest byte; newest byte meets the lowest char
    always_comb begin
        ph_a = !win_push[ssnps_pkg::LEN_A].word;
        for (int j = 0; j < ssnps_pkg::LEN_A; j++) begin
            ph_a = ph_a && (win_push[j].low == ssnps_pkg::PHRASE_A[8*j +: 8]);
        end
        ph_b = !win_push[ssnps_pkg::LEN_B].word;
        for (int j = 0; j < ssnps_pkg::LEN_B; j++) begin
            ph_b = ph_b && (win_push[j].low == ssnps_pkg::PHRASE_B[8*j +: 8]);
        end
        ph_c = !win_push[ssnps_pkg::LEN_C].word;
        for (int j = 0; j < ssnps_pkg::LEN_C; j++) begin
            ph_c = ph_c && (win_push[j].low == ssnps_pkg::PHRASE_C[8*j +: 8]);
        end
    end
    assign phrase_hit = active && (i_char_byte != 8'h00) && (ph_a || ph_b || ph_c);

    // zero byte stops the scan until the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stopped <= 1'b0;
        end else if (clear_en) begin
            r_stopped <= 1'b0;
        end else if (active && (i_char_byte == 8'h00)) begin
            r_stopped <= 1'b1;
        end
    end

    // check results into the scoring stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (!stall) begin
            r_b_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_b_last   <= i_last_byte;
            r_b_hit    <= close_en && tok_ok;
            r_b_phrase <= phrase_hit;
            r_b_digits <= tok_digits;
        end
    end

    ssnps_score u_score (
        .i_digits (r_b_digits),
        .o_score  (hit_score)
    );

    // running totals including the request in the scoring stage
    assign scored = r_b_hit && (hit_score != 2'd0);
    always_comb begin
        n_best   = (scored && hit_score > r_best) ? hit_score : r_best;
        n_total  = (scored && !(&r_total))
                 ? r_total + {{(COUNT_BITS-1){1'b0}}, 1'b1} : r_total;
        n_phrase = r_phrase || r_b_phrase;
        n_pri    = (n_best != 2'd0 && n_phrase) ? n_best + 2'd1 : n_best;
    end
    assign total_ext = {16'h0000, n_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best   <= 2'd0;
            r_total  <= '0;
            r_phrase <= 1'b0;
        end else if (!stall && r_b_valid) begin
            if (r_b_last) begin
                r_best   <= 2'd0;
                r_total  <= '0;
                r_phrase <= 1'b0;
            end else begin
                r_best   <= n_best;
                r_total  <= n_total;
                r_phrase <= n_phrase;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!stall && r_b_valid && r_b_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall && r_b_valid && r_b_last) begin
            r_out_pri   <= n_pri;
            r_out_count <= total_ext[15:0];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_priority_res = r_out_pri;
    assign o_match_count  = r_out_count;

endmodule

`default_nettype wire

// File: hw/rtl/ssnps_cell.sv
`default_nettype none

module ssnps_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_shift,
    input  wire                  i_clear,
    input  ssnps_pkg::t_char     i_data,
    output ssnps_pkg::t_char     o_data
);

    ssnps_pkg::t_char r_data;

    // one window byte: takes its neighbour's byte on a shift, zero byte on clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_data <= ssnps_pkg::classify(8'h00);
        end else if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// File: hw/rtl/ssnps_score.sv
`default_nettype none

module ssnps_score (
    input  wire  [35:0] i_digits,
    output logic [1:0]  o_score
);

    logic [9:0] area;
    logic       excluded;
    logic [1:0] band;

    // area from the first three digits
    assign area = 10'(i_digits[35:32]) * 10'd100
                + 10'(i_digits[31:28]) * 10'd10
                + 10'(i_digits[27:24]);

    // advertising numbers, empty group, empty serial
    assign excluded = (i_digits == ssnps_pkg::AD_NUM_A)
                   || (i_digits == ssnps_pkg::AD_NUM_B)
                   || (i_digits[35:4] == ssnps_pkg::AD_PREFIX)
                   || (i_digits[23:16] == 8'h00)
                   || (i_digits[15:0] == 16'h0000);

    always_comb begin
        if (area == 10'd0 || area == ssnps_pkg::AREA_BAD || area >= ssnps_pkg::AREA_LIMIT) begin
            band = 2'd0;
        end else if (area < ssnps_pkg::AREA_HI_END) begin
            band = 2'd2;
        end else if (area < ssnps_pkg::AREA_MID_END) begin
            band = 2'd1;
        end else if (area < ssnps_pkg::AREA_HI2_END) begin
            band = 2'd2;
        end else begin
            band = 2'd1;
        end
    end

    assign o_score = excluded ? 2'd0 : band;

endmodule

`default_nettype wire
